### src/slfp_pkg.sv
package slfp_pkg;

  // guard bits plus coordinate width
  localparam int GUARD_SUM = 62;

  typedef struct packed {
    logic vld;
    logic deg;
  } ctl_t;

endpackage

### src/slfp_front.sv
module slfp_front #(
  parameter int CW = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [CW-1:0]         start_x,
  input  logic [CW-1:0]         start_y,
  input  logic [CW-1:0]         end_x,
  input  logic [CW-1:0]         end_y,
  input  logic [CW-1:0]         point_x,
  input  logic [CW-1:0]         point_y,
  output logic [2*CW+1:0]       len_sq,
  output logic signed [2*CW+2:0] dot_n,
  output logic signed [2*CW+2:0] dot_a,
  output logic signed [2*CW+2:0] dot_b
);

  localparam int PW = 2 * CW + 2;

  logic signed [CW:0] dx, dy, ux, uy, vx, vy;
  logic signed [PW-1:0] pxx, pyy, pudy, pudx, puxx, puyy, pvxx, pvyy;
  logic [PW-1:0] lsum;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
      dy <= $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
      ux <= $signed({start_x[CW-1], start_x}) - $signed({point_x[CW-1], point_x});
      uy <= $signed({start_y[CW-1], start_y}) - $signed({point_y[CW-1], point_y});
      vx <= $signed({end_x[CW-1], end_x}) - $signed({point_x[CW-1], point_x});
      vy <= $signed({end_y[CW-1], end_y}) - $signed({point_y[CW-1], point_y});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx  <= PW'(dx * dx);
      pyy  <= PW'(dy * dy);
      pudy <= PW'(ux * dy);
      pudx <= PW'(uy * dx);
      puxx <= PW'(ux * dx);
      puyy <= PW'(uy * dy);
      pvxx <= PW'(vx * dx);
      pvyy <= PW'(vy * dy);
    end
  end

  // both squares are nonnegative and their sum fits PW bits unsigned
  assign lsum = pxx + pyy;

  always_ff @(posedge clk) begin
    if (en) begin
      len_sq <= lsum;
      dot_n  <= $signed({pudy[PW-1], pudy}) - $signed({pudx[PW-1], pudx});
      dot_a  <= $signed({puxx[PW-1], puxx}) + $signed({puyy[PW-1], puyy});
      dot_b  <= $signed({pvxx[PW-1], pvxx}) + $signed({pvyy[PW-1], pvyy});
    end
  end

endmodule

### src/slfp_sqrt.sv
module slfp_sqrt #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*CW+1:0]      len_sq,
  output logic [slfp_pkg::GUARD_SUM:0] root
);

  localparam int G  = slfp_pkg::GUARD_SUM - CW;
  localparam int SB = CW + 1 + G;
  localparam int RB = SB + 2;
  localparam int LW = 2 * CW + 2;

  logic [RB-1:0] rem [SB+1];
  logic [SB-1:0] rt  [SB+1];
  logic [LW-1:0] lv  [SB+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign lv[0]  = len_sq;

  for (genvar k = 0; k < SB; k++) begin : g_step
    logic [1:0]    dg;
    logic [RB-1:0] cur, trial;
    if (k <= CW) begin : g_dig
      assign dg = lv[k][2*(CW-k) +: 2];
    end else begin : g_zero
      assign dg = 2'b00;
    end
    assign cur   = {rem[k][RB-3:0], dg};
    assign trial = {rt[k], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        lv[k+1] <= lv[k];
        if (cur >= trial) begin
          rem[k+1] <= cur - trial;
          rt[k+1]  <= {rt[k][SB-2:0], 1'b1};
        end else begin
          rem[k+1] <= cur;
          rt[k+1]  <= {rt[k][SB-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[SB];

endmodule

### src/slfp_div.sv
module slfp_div #(
  parameter int CW = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [2*CW+2:0]        dot,
  input  logic [slfp_pkg::GUARD_SUM:0]  den_in,
  output logic [CW-1:0]                 result
);

  localparam int G  = slfp_pkg::GUARD_SUM - CW;
  localparam int SB = slfp_pkg::GUARD_SUM + 1;
  localparam int MW = 2 * CW + 2;
  localparam int NW = MW + G;
  localparam int QB = CW + 1;

  logic [NW-1:0] rem [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [SB-1:0] den [QB+1];
  logic          neg [QB+1];
  logic [2*CW+2:0] mag;

  assign mag = dot[2*CW+2] ? -dot : dot;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {mag[MW-1:0], {G{1'b0}}};
      q[0]   <= '0;
      den[0] <= den_in;
      neg[0] <= dot[2*CW+2];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [NW-1:0] sh;
    assign sh = NW'(den[j]) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        den[j+1] <= den[j];
        neg[j+1] <= neg[j];
        if (rem[j] >= sh) begin
          rem[j+1] <= rem[j] - sh;
          q[j+1]   <= {q[j][QB-2:0], 1'b1};
        end else begin
          rem[j+1] <= rem[j];
          q[j+1]   <= {q[j][QB-2:0], 1'b0};
        end
      end
    end
  end

  logic [QB-1:0] lim, mq, sv;

  always_comb begin
    lim = neg[QB] ? QB'(1) << (CW - 1) : (QB'(1) << (CW - 1)) - QB'(1);
    mq  = (q[QB] > lim) ? lim : q[QB];
    sv  = neg[QB] ? -mq : mq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= sv[CW-1:0];
    end
  end

endmodule

### src/segment_local_frame_projection.sv
// Throughput: one word per cycle while the output is not stalled; the root
// stage (one bit per stage) and the three divider lanes (one quotient bit
// per stage) are fully pipelined.
// A stalled output freezes the whole pipeline in place.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module segment_local_frame_projection #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  input  logic [COORD_WIDTH-1:0] point_x,
  input  logic [COORD_WIDTH-1:0] point_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] normal_offset,
  output logic [COORD_WIDTH-1:0] along_start,
  output logic [COORD_WIDTH-1:0] along_end,
  output logic                   degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int SB  = slfp_pkg::GUARD_SUM + 1;
  localparam int QB  = CW + 1;
  localparam int DW  = 2 * CW + 3;
  localparam int LAT = 3 + SB + QB + 2;

  logic adv;
  slfp_pkg::ctl_t ctl [LAT];

  assign adv      = !ctl[LAT-1].vld || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        ctl[i].vld <= 1'b0;
        ctl[i].deg <= 1'b0;
      end
    end else if (adv) begin
      ctl[0].vld <= in_valid;
      ctl[0].deg <= (start_x == end_x) && (start_y == end_y);
      for (int i = 1; i < LAT; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  logic [2*CW+1:0]       len_sq;
  logic signed [DW-1:0]  dot_n, dot_a, dot_b;
  logic [SB-1:0]         root;

  slfp_front #(.CW(CW)) u_front (
    .clk, .en(adv),
    .start_x, .start_y, .end_x, .end_y, .point_x, .point_y,
    .len_sq, .dot_n, .dot_a, .dot_b
  );

  slfp_sqrt #(.CW(CW)) u_sqrt (
    .clk, .en(adv), .len_sq, .root
  );

  logic signed [DW-1:0] dly_n [SB];
  logic signed [DW-1:0] dly_a [SB];
  logic signed [DW-1:0] dly_b [SB];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_n[0] <= dot_n;
      dly_a[0] <= dot_a;
      dly_b[0] <= dot_b;
      for (int i = 1; i < SB; i++) begin
        dly_n[i] <= dly_n[i-1];
        dly_a[i] <= dly_a[i-1];
        dly_b[i] <= dly_b[i-1];
      end
    end
  end

  logic [CW-1:0] res_n, res_a, res_b;

  slfp_div #(.CW(CW)) u_div_n (
    .clk, .en(adv), .dot(dly_n[SB-1]), .den_in(root), .result(res_n)
  );
  slfp_div #(.CW(CW)) u_div_a (
    .clk, .en(adv), .dot(dly_a[SB-1]), .den_in(root), .result(res_a)
  );
  slfp_div #(.CW(CW)) u_div_b (
    .clk, .en(adv), .dot(dly_b[SB-1]), .den_in(root), .result(res_b)
  );

  assign out_valid     = ctl[LAT-1].vld;
  assign degenerate    = ctl[LAT-1].deg;
  assign normal_offset = ctl[LAT-1].deg ? '0 : res_n;
  assign along_start   = ctl[LAT-1].deg ? '0 : res_a;
  assign along_end     = ctl[LAT-1].deg ? '0 : res_b;

endmodule

### src/slfp_checker.sv
module slfp_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [COORD_WIDTH-1:0] start_x,
  input logic [COORD_WIDTH-1:0] start_y,
  input logic [COORD_WIDTH-1:0] end_x,
  input logic [COORD_WIDTH-1:0] end_y,
  input logic [COORD_WIDTH-1:0] point_x,
  input logic [COORD_WIDTH-1:0] point_y,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] normal_offset,
  input logic [COORD_WIDTH-1:0] along_start,
  input logic [COORD_WIDTH-1:0] along_end,
  input logic                   degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_offset)
      && $stable(along_start) && $stable(along_end) && $stable(degenerate))
    else $error("output word changed while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_offset == '0 && along_start == '0
      && along_end == '0)
    else $error("degenerate word with nonzero outputs");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid word after reset");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind segment_local_frame_projection slfp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (.*);

### tb/sv/testbench.sv
module testbench;

  localparam int CW = 32;
  localparam int GUARD = 62 - CW;
  localparam int N_RANDOM = 1630;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [CW-1:0] normal_offset;
    logic [CW-1:0] along_start;
    logic [CW-1:0] along_end;
    logic          degenerate;
  } frame_t;

  typedef struct {
    logic [CW-1:0] ax, ay, bx, by, px, py;
    bit            typed;
    frame_t        res;
  } seg_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [CW-1:0] point_x = '0, point_y = '0;
  logic in_ready, out_valid, degenerate;
  logic [CW-1:0] normal_offset, along_start, along_end;

  frame_t frame_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_degen = 0;
  int cycles = 0;
  int out_wait = 0;
  bit got_word = 0;

  segment_local_frame_projection #(.COORD_WIDTH(CW)) dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_local_frame_projection: mismatch");
      $finish;
    end
  end

  function automatic logic [127:0] root_of(logic [127:0] n);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] project_on(logic signed [127:0] dot,
                                               logic [127:0] len);
    logic neg;
    logic [127:0] mag, q, lim;
    neg = dot < 0;
    mag = neg ? -dot : dot;
    q = (mag << GUARD) / len;
    lim = (128'd1 << (CW - 1)) - (neg ? 0 : 1);
    if (q > lim) q = lim;
    return neg ? -q[CW-1:0] : q[CW-1:0];
  endfunction

  function automatic frame_t local_frame(logic signed [CW-1:0] ax, ay, bx, by, px, py);
    logic signed [127:0] dx, dy, ux, uy, vx, vy;
    logic [127:0] len;
    frame_t f;
    dx = bx - ax; dy = by - ay;
    ux = ax - px; uy = ay - py;
    vx = bx - px; vy = by - py;
    f = '0;
    if (dx == 0 && dy == 0) begin
      f.degenerate = 1;
      return f;
    end
    len = root_of((dx * dx + dy * dy) << (2 * GUARD));
    f.normal_offset = project_on(ux * dy - uy * dx, len);
    f.along_start = project_on(ux * dx + uy * dy, len);
    f.along_end = project_on(vx * dx + vy * dy, len);
    return f;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {$urandom()} ;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
    endcase
  endfunction

  // valid stays high after the word is taken; idle_input, or a gap in the next call, drops it
  task automatic send_seg(logic [CW-1:0] ax, ay, bx, by, px, py, bit typed, frame_t res);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    start_x <= ax; start_y <= ay; end_x <= bx; end_y <= by;
    point_x <= px; point_y <= py;
    in_valid <= 1;
    frame_q.push_back(typed ? res : local_frame(ax, ay, bx, by, px, py));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 0;
  endtask

  always @(negedge clk) begin
    int w;
    w = out_wait;
    if (got_word) w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (w > 0) begin
      out_ready <= 1'b0;
      w--;
    end else begin
      out_ready <= 1'b1;
    end
    out_wait <= w;
  end

  always @(posedge clk) begin
    frame_t exp_f;
    got_word <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      n_recv++;
      if (degenerate) n_degen++;
      if (frame_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_f = frame_q.pop_front();
        if (normal_offset !== exp_f.normal_offset) begin
          $error("normal_offset exp %h got %h", exp_f.normal_offset, normal_offset);
          errors++;
        end
        if (along_start !== exp_f.along_start) begin
          $error("along_start exp %h got %h", exp_f.along_start, along_start);
          errors++;
        end
        if (along_end !== exp_f.along_end) begin
          $error("along_end exp %h got %h", exp_f.along_end, along_end);
          errors++;
        end
        if (degenerate !== exp_f.degenerate) begin
          $error("degenerate exp %b got %b", exp_f.degenerate, degenerate);
          errors++;
        end
      end
    end
  end

  seg_row_t rows[$];
  localparam logic [CW-1:0] MAXV = 32'h7FFFFFFF, MINV = 32'h80000000, ONE = 32'h00010000;

  initial begin
    frame_t z, d;
    z = '0;
    d = '0; d.degenerate = 1;
    // zero-length segments
    rows.push_back('{0, 0, 0, 0, 0, 0, 1, d});
    rows.push_back('{MAXV, MINV, MAXV, MINV, MINV, MAXV, 1, d});
    rows.push_back('{ONE, ONE, ONE, ONE, 0, 0, 1, d});
    // unit segment along x, point at origin
    rows.push_back('{0, 0, ONE, 0, 0, 0, 0, z});
    rows.push_back('{0, 0, ONE, 0, 0, ONE, 0, z});
    rows.push_back('{0, 0, 0, ONE, ONE, 0, 0, z});
    rows.push_back('{MINV, MINV, MAXV, MAXV, 0, 0, 0, z});
    rows.push_back('{MAXV, MAXV, MINV, MINV, MINV, MAXV, 0, z});
    rows.push_back('{MINV, 0, MAXV, 0, MAXV, MINV, 0, z});
    rows.push_back('{0, MINV, 0, MAXV, MINV, MAXV, 0, z});
    rows.push_back('{0, 0, 1, 0, MAXV, MINV, 0, z});
    rows.push_back('{0, 0, 1, 1, MINV, MAXV, 0, z});
    rows.push_back('{MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, z});
    rows.push_back('{32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 0, z});
    rows.push_back('{32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9, 32'h87654321, 1, 32'hFFFFFFFF, 0, z});
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i])
      send_seg(rows[i].ax, rows[i].ay, rows[i].bx, rows[i].by, rows[i].px, rows[i].py,
               rows[i].typed, rows[i].res);
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [CW-1:0] ax, ay, bx, by, px, py;
      if (i == N_RANDOM / 2) begin
        idle_input();
        while (frame_q.size() != 0) @(negedge clk);
      end
      ax = rand_coord(); ay = rand_coord(); px = rand_coord(); py = rand_coord();
      if ($urandom_range(0, 19) == 0) begin
        bx = ax; by = ay;
      end else if ($urandom_range(0, 4) == 0) begin
        bx = ax + $signed($urandom_range(0, 8)) - 4;
        by = ay + $signed($urandom_range(0, 8)) - 4;
      end else begin
        bx = rand_coord(); by = rand_coord();
      end
      send_seg(ax, ay, bx, by, px, py, 0, z);
    end
    idle_input();
    while (frame_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    $display("covered %0d segments, %0d results, %0d zero-length", n_sent, n_recv, n_degen);
    if (errors == 0) begin
      $display("segment_local_frame_projection: match");
    end else begin
      $display("segment_local_frame_projection: mismatch");
    end
    $finish;
  end

endmodule
